// ===== rtl/core/afc_pkg.sv =====
// Package for the box frustum culling block: widths, plane layout and helpers.
// Used by every module under rtl/core; depends on nothing else.
package afc_pkg;

  localparam int unsigned DefCoordBits = 16;
  localparam int unsigned SlotBits     = 16;
  localparam int unsigned NumPlanes    = 6;
  localparam int unsigned PlaneBits    = 64;
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned QueueDepth   = 4;

  localparam logic [CfgIdxBits-1:0] RegLeft   = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegRight  = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegTop    = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegBottom = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegNear   = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegFar    = 3'd5;

  // World centre and extents: 16 fraction bits. Products of two 16-bit
  // values fit in 32 bits; three of them plus a shifted position in 35.
  localparam int unsigned WorldBits = 35;
  // Plane terms: 35-bit world value times 16-bit normal, summed over three
  // axes with the offset and radius folded in.
  localparam int unsigned TermBits  = 51;
  localparam int unsigned DistBits  = 55;

  typedef logic signed [WorldBits-1:0] world_t;
  typedef logic signed [TermBits-1:0]  term_t;
  typedef logic signed [DistBits-1:0]  dist_t;
  typedef logic [PlaneBits-1:0]        plane_t;

endpackage

// ===== rtl/core/afc_front.sv =====
// Front end: takes input items and transforms the box into world space.
// Depends on afc_pkg. Two register stages; stalls when the queue holds more than QueueDepth-3 entries.
module afc_front #(
  parameter int unsigned COORD_BITS = afc_pkg::DefCoordBits
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic [3*afc_pkg::SlotBits-1:0]          world_right_axis,
  input  logic [3*afc_pkg::SlotBits-1:0]          world_up_axis,
  input  logic [3*afc_pkg::SlotBits-1:0]          world_back_axis,
  input  logic [3*afc_pkg::SlotBits-1:0]          world_position,
  input  logic [3*afc_pkg::SlotBits-1:0]          box_center,
  input  logic [3*afc_pkg::SlotBits-1:0]          box_half_extent,
  input  logic                                    advance,
  output logic                                    out_valid,
  output afc_pkg::world_t                         wc [3],
  output afc_pkg::world_t                         we [3]
);
  import afc_pkg::*;

  typedef logic signed [COORD_BITS-1:0]   coord_t;
  typedef logic signed [2*COORD_BITS-1:0] prod_t;

  coord_t ax [3][3];
  coord_t pos [3];
  coord_t c [3];
  coord_t e [3];
  prod_t  pc [3][3];
  prod_t  pe [3][3];
  coord_t pos_s1 [3];
  logic   v1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ax[0][k] = world_right_axis[SlotBits*k +: COORD_BITS];
      ax[1][k] = world_up_axis[SlotBits*k +: COORD_BITS];
      ax[2][k] = world_back_axis[SlotBits*k +: COORD_BITS];
      pos[k]   = world_position[SlotBits*k +: COORD_BITS];
      c[k]     = box_center[SlotBits*k +: COORD_BITS];
      e[k]     = box_half_extent[SlotBits*k +: COORD_BITS];
    end
  end

  // Stage one registers the axis-by-component products.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
    end
    if (advance) begin
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          pc[a][k] <= ax[a][k] * c[a];
          pe[a][k] <= ax[a][k] * e[a];
        end
      end
      pos_s1 <= pos;
    end
  end

  // Stage two sums the products into world centre and extents.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v1;
    end
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        wc[k] <= WorldBits'(pc[0][k]) + WorldBits'(pc[1][k]) + WorldBits'(pc[2][k])
               + (WorldBits'(pos_s1[k]) <<< 8);
        we[k] <= WorldBits'(pe[0][k] < 0 ? -pe[0][k] : pe[0][k])
               + WorldBits'(pe[1][k] < 0 ? -pe[1][k] : pe[1][k])
               + WorldBits'(pe[2][k] < 0 ? -pe[2][k] : pe[2][k]);
      end
    end
  end

endmodule

// ===== rtl/core/afc_queue.sv =====
// Short FIFO between the front and back ends, holding world centre and extents.
// Depends on afc_pkg. Flop based, first-word fall-through.
module afc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  afc_pkg::world_t push_wc [3],
  input  afc_pkg::world_t push_we [3],
  input  logic            pop,
  output logic            not_empty,
  output logic [$clog2(afc_pkg::QueueDepth):0] level,
  output afc_pkg::world_t head_wc [3],
  output afc_pkg::world_t head_we [3]
);
  import afc_pkg::*;

  localparam int unsigned PtrBits = $clog2(QueueDepth);

  world_t            mem_wc [QueueDepth][3];
  world_t            mem_we [QueueDepth][3];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [PtrBits:0]   count;

  assign not_empty = (count != '0);
  assign level     = count;
  assign head_wc   = mem_wc[rd_ptr];
  assign head_we   = mem_we[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
    end
    if (push) begin
      mem_wc[wr_ptr] <= push_wc;
      mem_we[wr_ptr] <= push_we;
    end
  end

endmodule

// ===== rtl/core/afc_back.sv =====
// Back end: tests a world-space box against the six planes.
// Depends on afc_pkg. Two register stages plus an output register.
module afc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  afc_pkg::world_t     wc [3],
  input  afc_pkg::world_t     we [3],
  input  afc_pkg::plane_t     planes [afc_pkg::NumPlanes],
  output logic                take,
  output logic                out_valid,
  output logic                visible,
  input  logic                out_stall
);
  import afc_pkg::*;

  logic signed [SlotBits-1:0] n [NumPlanes][3];
  logic signed [SlotBits:0]   n_mag [NumPlanes][3];
  logic signed [SlotBits-1:0] off [NumPlanes];
  term_t  td [NumPlanes][3];
  term_t  tr [NumPlanes][3];
  logic signed [SlotBits-1:0] off_s1 [NumPlanes];
  logic   v1, v2;
  logic [NumPlanes-1:0] pass;
  logic   adv;
  dist_t  sum [NumPlanes];

  // The pipe moves whenever the output register is free or being emptied.
  assign adv  = !out_valid || !out_stall;
  assign take = in_valid && adv;

  // The normal magnitude is one bit wider so that the most negative normal
  // gives a positive magnitude.
  always_comb begin
    for (int p = 0; p < NumPlanes; p++) begin
      for (int k = 0; k < 3; k++) begin
        n[p][k]     = planes[p][SlotBits*k +: SlotBits];
        n_mag[p][k] = (n[p][k] < 0) ? -(SlotBits+1)'(n[p][k]) : (SlotBits+1)'(n[p][k]);
      end
      off[p] = planes[p][3*SlotBits +: SlotBits];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= take;
      v2 <= v1;
      out_valid <= v2;
    end
    if (adv) begin
      for (int p = 0; p < NumPlanes; p++) begin
        for (int k = 0; k < 3; k++) begin
          td[p][k] <= TermBits'(wc[k]) * TermBits'(n[p][k]);
          tr[p][k] <= TermBits'(we[k]) * TermBits'(n_mag[p][k]);
        end
        off_s1[p] <= off[p];
      end
      for (int p = 0; p < NumPlanes; p++) pass[p] <= !sum[p][DistBits-1];
      visible <= &pass;
    end
  end

  // d + r, with the offset scaled up to 30 fraction bits.
  always_comb begin
    for (int p = 0; p < NumPlanes; p++) begin
      sum[p] = DistBits'(td[p][0]) + DistBits'(td[p][1]) + DistBits'(td[p][2])
             + DistBits'(tr[p][0]) + DistBits'(tr[p][1]) + DistBits'(tr[p][2])
             - (DistBits'(off_s1[p]) <<< 22);
    end
  end

endmodule

// ===== rtl/core/aabb_frustum_cull.sv =====
// Top level of the box frustum culling block: plane registers, front, queue, back.
// Depends on afc_pkg, afc_front, afc_queue and afc_back.
//
// Usage: an object arrives on the input channel (in_valid, in_stall and six
// 48-bit fields, three Q8.8 components each, x lowest) and one bit, visible,
// leaves on the output channel (out_valid, out_stall). A transfer happens at
// a rising edge where valid is high and stall is low.
// Throughput is one item per cycle while the receiver does not stall. From input
// transfer to output valid, when the queue is empty, an item passes two front
// stages that build world centre and extents, one queue slot, two back stages
// that form the plane distances and an output register.
// The six planes are written through cfg_we, cfg_index and cfg_data while
// the block is idle; an index above five is ignored.
// Reset is synchronous and clears all planes to zero (every plane passes)
// and empties the pipeline. When the receiver stalls, the back end holds,
// the queue fills, and once it can no longer take what the front end still
// holds, in_stall is raised. The output register keeps its value while
// stalled.
module aabb_frustum_cull #(
  parameter int unsigned COORD_BITS = afc_pkg::DefCoordBits
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [afc_pkg::CfgIdxBits-1:0]         cfg_index,
  input  logic [afc_pkg::PlaneBits-1:0]          cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [3*afc_pkg::SlotBits-1:0]         world_right_axis,
  input  logic [3*afc_pkg::SlotBits-1:0]         world_up_axis,
  input  logic [3*afc_pkg::SlotBits-1:0]         world_back_axis,
  input  logic [3*afc_pkg::SlotBits-1:0]         world_position,
  input  logic [3*afc_pkg::SlotBits-1:0]         box_center,
  input  logic [3*afc_pkg::SlotBits-1:0]         box_half_extent,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   visible
);
  import afc_pkg::*;

  plane_t planes [NumPlanes];
  world_t f_wc [3], f_we [3], q_wc [3], q_we [3];
  logic   f_valid, q_ne, take, advance;
  logic [$clog2(QueueDepth):0] level;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NumPlanes; p++) planes[p] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegLeft:   planes[0] <= cfg_data;
        RegRight:  planes[1] <= cfg_data;
        RegTop:    planes[2] <= cfg_data;
        RegBottom: planes[3] <= cfg_data;
        RegNear:   planes[4] <= cfg_data;
        RegFar:    planes[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front end runs free while the queue has room for everything it holds:
  // up to two items in flight, so it advances while at most QueueDepth-3
  // entries are taken.
  assign advance  = (level <= ($clog2(QueueDepth)+1)'(QueueDepth - 3));
  assign in_stall = !advance;

  afc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst, .in_valid,
    .world_right_axis, .world_up_axis, .world_back_axis,
    .world_position, .box_center, .box_half_extent,
    .advance, .out_valid(f_valid), .wc(f_wc), .we(f_we)
  );

  afc_queue u_queue (
    .clk, .rst,
    .push(f_valid && advance), .push_wc(f_wc), .push_we(f_we),
    .pop(take), .not_empty(q_ne), .level,
    .head_wc(q_wc), .head_we(q_we)
  );

  afc_back u_back (
    .clk, .rst, .in_valid(q_ne), .wc(q_wc), .we(q_we), .planes,
    .take, .out_valid, .visible, .out_stall
  );

endmodule

// ===== dv/afc_checker.sv =====
// Scoreboard for the box frustum culling block: mirrors the plane registers,
// predicts the visible bit of each input transfer and compares it with the output.
// Depends on afc_pkg for widths and register indexes.
module afc_checker #(
  parameter int unsigned COORD_BITS = afc_pkg::DefCoordBits
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [afc_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [afc_pkg::PlaneBits-1:0]  cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [47:0]                    world_right_axis,
  input  logic [47:0]                    world_up_axis,
  input  logic [47:0]                    world_back_axis,
  input  logic [47:0]                    world_position,
  input  logic [47:0]                    box_center,
  input  logic [47:0]                    box_half_extent,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           visible,
  output int                             errors,
  output int                             pending
);
  import afc_pkg::*;

  plane_t plane_copy [NumPlanes];
  logic   visible_q [$];

  function automatic longint slot_value(logic [47:0] f, int i, int w);
    longint t;
    t = longint'({48'b0, f[16*i +: 16]}) << (64 - w);
    return t >>> (64 - w);
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic cull_pass(logic [47:0] rx, logic [47:0] ux, logic [47:0] bx,
                                     logic [47:0] px, logic [47:0] cx, logic [47:0] ex);
    longint ctr [3];
    longint ext [3];
    longint n, off, rad, dst;
    logic   pass;
    pass = 1'b1;
    for (int k = 0; k < 3; k++) begin
      ctr[k] = slot_value(rx, k, COORD_BITS) * slot_value(cx, 0, COORD_BITS)
             + slot_value(ux, k, COORD_BITS) * slot_value(cx, 1, COORD_BITS)
             + slot_value(bx, k, COORD_BITS) * slot_value(cx, 2, COORD_BITS)
             + slot_value(px, k, COORD_BITS) * 256;
      ext[k] = mag(slot_value(rx, k, COORD_BITS) * slot_value(ex, 0, COORD_BITS))
             + mag(slot_value(ux, k, COORD_BITS) * slot_value(ex, 1, COORD_BITS))
             + mag(slot_value(bx, k, COORD_BITS) * slot_value(ex, 2, COORD_BITS));
    end
    for (int p = 0; p < NumPlanes; p++) begin
      rad = 0;
      dst = 0;
      for (int k = 0; k < 3; k++) begin
        n   = slot_value(plane_copy[p][47:0], k, 16);
        rad += ext[k] * mag(n);
        dst += ctr[k] * n;
      end
      off = slot_value({32'b0, plane_copy[p][63:48]}, 0, 16);
      dst -= off * (longint'(1) << 22);
      if (dst + rad < 0) pass = 1'b0;
    end
    return pass;
  endfunction

  assign pending = visible_q.size();

  always @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NumPlanes; p++) plane_copy[p] <= '0;
      visible_q.delete();
      errors <= 0;
    end else begin
      if (cfg_we && cfg_index < NumPlanes) plane_copy[cfg_index] <= cfg_data;
      if (in_valid && !in_stall)
        visible_q.push_back(cull_pass(world_right_axis, world_up_axis, world_back_axis,
                                      world_position, box_center, box_half_extent));
      if (out_valid && !out_stall) begin
        if (visible_q.size() == 0) begin
          if (errors < 10) $display("result with nothing expected: visible=%0b", visible);
          errors <= errors + 1;
        end else begin
          if (visible !== visible_q[0]) begin
            if (errors < 10)
              $display("visible mismatch: expected %0b got %0b", visible_q[0], visible);
            errors <= errors + 1;
          end
          void'(visible_q.pop_front());
        end
      end
    end
  end
endmodule

// ===== dv/tb_aabb_frustum_cull.sv =====
// Top of the culling testbench: clock, reset, stimulus, plane writes and verdict.
// Depends on afc_pkg, the aabb_frustum_cull block and the afc_checker scoreboard.
module tb_aabb_frustum_cull;
  import afc_pkg::*;

  localparam int CycleLimit = 300000;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [63:0]      cfg_data;
  logic             in_valid;
  logic             in_stall;
  logic [47:0]      f_right, f_up, f_back, f_pos, f_ctr, f_ext;
  logic             out_valid;
  logic             out_stall;
  logic             visible;
  int               errors;
  int               pending;
  int               idle_pct;
  int               stall_pct;
  int               hold_req;
  int               cycles;

  aabb_frustum_cull u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .world_right_axis(f_right), .world_up_axis(f_up), .world_back_axis(f_back),
    .world_position(f_pos), .box_center(f_ctr), .box_half_extent(f_ext),
    .out_valid(out_valid), .out_stall(out_stall), .visible(visible)
  );

  afc_checker u_chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .world_right_axis(f_right), .world_up_axis(f_up), .world_back_axis(f_back),
    .world_position(f_pos), .box_center(f_ctr), .box_half_extent(f_ext),
    .out_valid(out_valid), .out_stall(out_stall), .visible(visible),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // A run that hangs is ended here, well beyond the slowest correct run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_aabb_frustum_cull: done, errors");
      $finish;
    end
  end

  // The receiver stalls at random at the current rate. A long hold-off asked
  // for by the stimulus is counted down here, so that the block fills up and
  // pushes back on its input while the sender keeps offering transfers.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // Three small signed Q8.8 components, within +/- lim.
  function automatic logic [47:0] rand_vec(int lim);
    logic [47:0] v;
    for (int k = 0; k < 3; k++) v[16*k +: 16] = 16'($urandom_range(2*lim) - lim);
    return v;
  endfunction

  // Offers one transfer and holds it until it is taken. Afterwards the
  // sender may go idle for a while; valid is lowered here only after a transfer,
  // and raised again at a later falling edge, never twice in one step.
  task automatic offer(logic [47:0] r, logic [47:0] u, logic [47:0] b,
                       logic [47:0] p, logic [47:0] c, logic [47:0] e);
    f_right = r; f_up = u; f_back = b; f_pos = p; f_ctr = c; f_ext = e;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Waits until every expected result has arrived, so that a plane write never overtakes a transfer.
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_plane(logic [2:0] idx, logic [63:0] value);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Plane flavours: fully random bits, a unit axis normal with a modest
  // offset (a box-shaped frustum that lets objects through), or the extremes.
  function automatic logic [63:0] pick_plane(int flavour, int axis);
    logic [63:0] v;
    v = '0;
    case (flavour)
      0: v = {$urandom, $urandom};
      1: begin
        v[16*(axis%3) +: 16] = (axis < 3) ? 16'h4000 : 16'hC000;
        v[63:48] = 16'($urandom_range(2048) - 3072);
      end
      2: v = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
      default: v = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
    endcase
    return v;
  endfunction

  task automatic load_planes(int flavour);
    write_plane(RegLeft,   pick_plane(flavour, 0));
    write_plane(RegRight,  pick_plane(flavour, 3));
    write_plane(RegTop,    pick_plane(flavour, 1));
    write_plane(RegBottom, pick_plane(flavour, 4));
    write_plane(RegNear,   pick_plane(flavour, 2));
    write_plane(RegFar,    pick_plane(flavour, 5));
  endtask

  // Mostly well-formed objects with small random axes, with some
  // fully random items mixed in; negative extents turn up now and then.
  task automatic random_item();
    if ($urandom_range(3) == 0) begin
      offer(rand48(), rand48(), rand48(), rand48(), rand48(), rand48());
    end else begin
      offer(rand_vec(512), rand_vec(512), rand_vec(512),
            rand_vec(3000), rand_vec(1500), rand_vec(800));
    end
  endtask

  initial begin : stimulus
    logic [47:0] one3;
    int mode;
    one3      = {16'h0100, 16'h0100, 16'h0100};
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    f_right = '0; f_up = '0; f_back = '0; f_pos = '0; f_ctr = '0; f_ext = '0;
    out_stall = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Planes after reset are all zero, so everything must pass, including
    // the extremes of every field and wildly negative extents.
    offer('0, '0, '0, '0, '0, '0);
    offer('1, '1, '1, '1, '1, '1);
    offer({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
          {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    offer({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
          {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h8000}});
    drain();

    // Writes to indexes beyond five must be ignored.
    write_plane(3'd6, {16'h7FFF, 48'h0000_0000_4000});
    write_plane(3'd7, {16'h7FFF, 48'h0000_0000_4000});
    offer('0, '0, '0, '0, '0, '0);
    drain();

    // Only the left plane, x >= 0: centres just on, just behind, and
    // behind but reached by the extent, also when that extent is negative.
    write_plane(RegLeft, 64'h0000_0000_0000_4000);
    offer(one3, one3, one3, '0, '0, '0);
    offer(48'h0000_0000_0100, 48'h0000_0100_0000, 48'h0100_0000_0000,
          '0, 48'h0000_0000_FFFF, '0);
    offer(48'h0000_0000_0100, 48'h0000_0100_0000, 48'h0100_0000_0000,
          '0, 48'h0000_0000_FF00, 48'h0000_0000_0100);
    offer(48'h0000_0000_0100, 48'h0000_0100_0000, 48'h0100_0000_0000,
          '0, 48'h0000_0000_FF00, 48'h0000_0000_FF00);
    offer(48'h0000_0000_0100, 48'h0000_0100_0000, 48'h0100_0000_0000,
          48'h0000_0000_FFFF, '0, '0);
    offer(48'h0000_0000_FF00, '0, '0, '0, 48'h0000_0000_0100, '0);
    drain();

    // Extreme planes against extreme objects.
    load_planes(2);
    offer({3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}},
          {3{16'h8000}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    offer({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
          {3{16'h7FFF}}, {3{16'h8000}}, '0);
    drain();
    load_planes(3);
    offer({3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}},
          {3{16'h7FFF}}, {3{16'h8000}}, {3{16'h8000}});
    offer('1, '1, '1, '1, '1, '1);
    drain();

    // Random phases: each picks a plane flavour, an idling pattern and a receiver stall rate.
    for (int ph = 0; ph < 8; ph++) begin
      mode = ph % 4;
      load_planes((ph == 5) ? 0 : ((ph == 6) ? 2 : 1));
      idle_pct  = (mode == 1) ? 49 : ((mode == 3) ? 20 : 0);
      stall_pct = (mode == 2) ? 49 : ((mode == 3) ? 20 : 0);
      for (int i = 0; i < 56; i++) begin
        if (ph == 2 && i == 10) hold_req = 200;
        if (ph == 4 && i == 30) begin
          in_valid = 1'b0;
          while (pending != 0) @(negedge clk);
        end
        random_item();
      end
      drain();
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_aabb_frustum_cull: done, clean");
    end else begin
      $display("tb_aabb_frustum_cull: done, errors");
    end
    $finish;
  end
endmodule
